FILE: sv/abrd_pkg.sv
// Shared types and constants for the auto baud rate detector.
// No dependencies; every other file imports this package.
package abrd_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned THR_W  = 10;
   localparam int unsigned BAUD_W = 22;
   localparam int unsigned QUO_W  = 20;
   localparam int unsigned CNT_W  = $clog2(QUO_W);
   localparam int unsigned RATE_N = 9;

   // one second in microseconds, the divider's fixed dividend
   localparam logic [QUO_W-1:0] US_PER_SEC = 20'd1000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_SNAP,
      ST_LOAD
   } state_type;

   typedef enum logic {
      CSR_MIN_PULSE = 1'b0,
      CSR_FALLBACK  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic snap;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
      logic out_free;
   } status_type;

   localparam logic [BAUD_W-1:0] STD_RATE [RATE_N] = '{
      22'd9600, 22'd19200, 22'd38400, 22'd57600, 22'd115200,
      22'd230400, 22'd250000, 22'd500000, 22'd1000000
   };

   // midpoints between neighbouring rates, rounded down: a tie picks the lower rate
   localparam logic [QUO_W-1:0] SNAP_LIMIT [RATE_N-1] = '{
      20'd14400, 20'd28800, 20'd48000, 20'd86400,
      20'd172800, 20'd240200, 20'd375000, 20'd750000
   };

   function automatic logic [BAUD_W-1:0] snap_rate(input logic [TIME_W-1:0] raw);
      logic [BAUD_W-1:0] rate;
      rate = STD_RATE[RATE_N-1];
      for (int i = RATE_N - 2; i >= 0; i--) begin
         if (raw <= TIME_W'(SNAP_LIMIT[i])) begin
            rate = STD_RATE[i];
         end
      end
      return rate;
   endfunction

endpackage

FILE: sv/abrd_ifs.sv
// Handshake channels of the auto baud rate detector: request, response, CSR write.
// Depends on abrd_pkg for field widths.
interface abrd_req_if
   import abrd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              command;
   logic [TIME_W-1:0] edge_time_us;

   modport source (output valid, command, edge_time_us, input ready);
   modport sink   (input valid, command, edge_time_us, output ready);
endinterface

interface abrd_rsp_if
   import abrd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              detected;
   logic [TIME_W-1:0] min_pulse;
   logic [BAUD_W-1:0] baud;

   modport source (output valid, detected, min_pulse, baud, input ready);
   modport sink   (input valid, detected, min_pulse, baud, output ready);
endinterface

interface abrd_csr_if
   import abrd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   csr_idx_type       index;
   logic [BAUD_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/abrd_ctrl.sv
// Controller state machine: sequences accept, divide, snap and result load.
// Depends on abrd_pkg (state, command and status types).
module abrd_ctrl
   import abrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = status.need_div ? ST_DIV : ST_SNAP;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EVAL: begin
            cmd.div_start = status.need_div;
         end
         ST_SNAP: begin
            cmd.snap = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sv/abrd_div.sv
// Restoring divider: one second in microseconds over the pulse width, one bit a cycle.
// Depends on abrd_pkg (widths and dividend constant).
module abrd_div
   import abrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] divisor,
   output logic              busy,
   output logic [QUO_W-1:0]  quotient
);

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [TIME_W-1:0] dvs_ff;
   logic [QUO_W-1:0]  quo_ff;

   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, US_PER_SEC[cnt_ff]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CNT_W'(QUO_W - 1);
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/abrd_dpath.sv
// Datapath: CSRs, edge state, minimum pulse tracking, rate snapping, result register.
// Depends on abrd_pkg and abrd_div.
module abrd_dpath
   import abrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_command,
   input  logic [TIME_W-1:0] req_edge_time_us,
   input  logic              csr_valid,
   input  csr_idx_type       csr_index,
   input  logic [BAUD_W-1:0] csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_detected,
   output logic [TIME_W-1:0] rsp_min_pulse,
   output logic [BAUD_W-1:0] rsp_baud
);

   logic [THR_W-1:0]  thr_ff;
   logic [BAUD_W-1:0] fallback_ff;
   logic [TIME_W-1:0] last_edge_ff;
   logic [TIME_W-1:0] shortest_ff;
   logic              found_ff;
   logic [BAUD_W-1:0] baud_ff;
   logic              rsp_valid_ff;
   logic              rsp_detected_ff;
   logic [TIME_W-1:0] rsp_min_pulse_ff;
   logic [BAUD_W-1:0] rsp_baud_ff;

   logic [TIME_W-1:0] pulse;
   logic [TIME_W-1:0] raw;
   logic [QUO_W-1:0]  quotient;
   logic              div_busy;
   logic              no_pulse;

   abrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (shortest_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THR_W'(5);
         fallback_ff <= BAUD_W'(115200);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_PULSE: thr_ff      <= csr_data[THR_W-1:0];
            CSR_FALLBACK:  fallback_ff <= csr_data;
            default:       thr_ff      <= thr_ff;
         endcase
      end
   end

   assign pulse = req_edge_time_us - last_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         shortest_ff  <= '1;
         found_ff     <= 1'b0;
      end else if (cmd.accept) begin
         if (req_command) begin
            // restart: keep the last edge time
            shortest_ff <= '1;
            found_ff    <= 1'b0;
         end else begin
            last_edge_ff <= req_edge_time_us;
            if (pulse >= TIME_W'(thr_ff) && pulse < shortest_ff) begin
               shortest_ff <= pulse;
               found_ff    <= 1'b1;
            end
         end
      end
   end

   assign no_pulse = !found_ff || shortest_ff == '1;
   assign raw      = (shortest_ff == '0) ? '1 : TIME_W'(quotient);

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         baud_ff <= no_pulse ? fallback_ff : snap_rate(raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_detected_ff  <= found_ff;
         rsp_min_pulse_ff <= shortest_ff;
         rsp_baud_ff      <= baud_ff;
      end
   end

   assign status.need_div = !no_pulse && shortest_ff != '0;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_detected  = rsp_detected_ff;
   assign rsp_min_pulse = rsp_min_pulse_ff;
   assign rsp_baud      = rsp_baud_ff;

endmodule

FILE: sv/auto_baud_rate_detector.sv
// Auto baud rate detector: one response per request.
// A request passes accept, evaluate, divide (only when a nonzero pulse is held), snap and load.
// A new request is taken only once the last is loaded; the 20-step restoring divider sets the pace.
// The response register lets the next request in while a response waits.
// Synchronous active-high reset: min pulse 5, fallback 115200, no pulse held.
// Depends on abrd_pkg, abrd_ifs, abrd_ctrl, abrd_dpath.
module auto_baud_rate_detector
   import abrd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   abrd_req_if.sink   req_ch,
   abrd_rsp_if.source rsp_ch,
   abrd_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   abrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   abrd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_ch.command),
      .req_edge_time_us (req_ch.edge_time_us),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_detected     (rsp_ch.detected),
      .rsp_min_pulse    (rsp_ch.min_pulse),
      .rsp_baud         (rsp_ch.baud)
   );

endmodule

FILE: sv/abrd_checker.sv
// Port-level checks for the auto baud rate detector, bound to the top level.
// Depends on abrd_pkg.
module abrd_checker
   import abrd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_detected,
   input logic [TIME_W-1:0] rsp_min_pulse,
   input logic [BAUD_W-1:0] rsp_baud
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_none_min_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_detected |-> rsp_min_pulse == '1)
      else $error("minimum pulse held without detection");

   a_std_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |->
         rsp_baud == STD_RATE[0] || rsp_baud == STD_RATE[1] || rsp_baud == STD_RATE[2] ||
         rsp_baud == STD_RATE[3] || rsp_baud == STD_RATE[4] || rsp_baud == STD_RATE[5] ||
         rsp_baud == STD_RATE[6] || rsp_baud == STD_RATE[7] || rsp_baud == STD_RATE[8])
      else $error("detected rate is not a standard rate");

endmodule

bind auto_baud_rate_detector abrd_checker u_abrd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_detected  (rsp_ch.detected),
   .rsp_min_pulse (rsp_ch.min_pulse),
   .rsp_baud      (rsp_ch.baud)
);
